@@ sv/error_diffusion_dither_gray_assert.svh @@
// Assertion macros for the gray error-diffusion dither block.
`ifndef ERROR_DIFFUSION_DITHER_GRAY_ASSERT_SVH
`define ERROR_DIFFUSION_DITHER_GRAY_ASSERT_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define EDDG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define EDDG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define EDDG_ASSERT_SAME(lbl, ante, cons, msg)
`define EDDG_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/eddg_pkg.sv @@
// Types, constants and arithmetic helpers of the gray error-diffusion dither block.
package eddg_pkg;

  // Field widths
  localparam int PIX_W      = 8;
  localparam int ERR_W      = 8;
  localparam int IMG_W_W    = 13;
  localparam int IMG_H_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int KW         = 3;
  localparam int PROD_W     = ERR_W + KW + 1;
  localparam int SUM_W      = PIX_W + 2;

  // Register reset values
  localparam logic [IMG_W_W-1:0] IMG_W_RESET = 13'd640;
  localparam logic [IMG_H_W-1:0] IMG_H_RESET = 16'd480;

  // Pixel levels
  localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;
  localparam logic [PIX_W-1:0] PIX_THRESH = 8'd127;

  // Diffusion weights, in sixteenths
  localparam logic [KW-1:0] K_UL   = 3'd1;
  localparam logic [KW-1:0] K_UP   = 3'd5;
  localparam logic [KW-1:0] K_UR   = 3'd3;
  localparam logic [KW-1:0] K_LEFT = 3'd7;
  localparam int            ERR_SHIFT = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Result item held in the output register
  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             end_of_line;
    logic             end_of_frame;
  } out_t;

  // floor(e * k / 16)
  function automatic logic signed [ERR_W-1:0] err_term(logic signed [ERR_W-1:0] e,
                                                       logic [KW-1:0] k);
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] s;
    p = PROD_W'(e) * $signed(PROD_W'(k));
    s = p >>> ERR_SHIFT;
    return ERR_W'(s);
  endfunction

  // v + t, clamped to 0..255
  function automatic logic [PIX_W-1:0] add_clamp(logic [PIX_W-1:0] v,
                                                 logic signed [ERR_W-1:0] t);
    logic signed [SUM_W-1:0] s;
    s = $signed({2'b00, v}) + SUM_W'(t);
    if (s < 0) begin
      return '0;
    end else if (s > $signed({2'b00, PIX_MAX})) begin
      return PIX_MAX;
    end else begin
      return s[PIX_W-1:0];
    end
  endfunction

endpackage

@@ sv/eddg_in_if.sv @@
// Input stream channel: one gray pixel per item.
interface eddg_in_if import eddg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

@@ sv/eddg_out_if.sv @@
// Output stream channel: one dithered pixel with line and frame marks per item.
interface eddg_out_if import eddg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             end_of_line;
  logic             end_of_frame;

  modport source (output valid, output pixel_out, output end_of_line, output end_of_frame,
                  input ready);
  modport sink   (input valid, input pixel_out, input end_of_line, input end_of_frame,
                  output ready);
endinterface

@@ sv/error_diffusion_dither_gray.sv @@
// Top level of the gray error-diffusion (Floyd-Steinberg) dither block.
//
//  channel  | dir | payload                                  | handshake
//  ---------+-----+------------------------------------------+------------------
//  pix_i    | in  | pixel_in[7:0]                            | valid/ready
//  pix_o    | out | pixel_out[7:0], end_of_line, end_of_frame| valid/ready
//  cfg      | in  | cfg_idx_i, cfg_data_i[15:0]              | cfg_we_i
//
//  One item per cycle unless output stalls; results pass stage and output registers.
//  The row error memory gives two reads and one write per cycle; the error of
//  the previous pixel closes the loop through one register each cycle.
//  After reset the block takes items at once; the row memory needs no clearing
//  since row 0 reads no upper terms.
//  A stalled output holds one result in the output register and one in the
//  compute stage; input ready drops only when both are full.

`include "error_diffusion_dither_gray_assert.svh"

module error_diffusion_dither_gray import eddg_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  eddg_in_if.sink               pix_i,
  eddg_out_if.source            pix_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;
  localparam int WW = (CW > IMG_W_W) ? CW : IMG_W_W;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [AW-1:0]    col;
    logic             has_up;
    logic             has_ur;
    logic             has_left;
    logic             eol;
    logic             eof;
  } s1_t;

  // Configuration registers
  logic [IMG_W_W-1:0] width_q;
  logic [IMG_H_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= IMG_W_RESET;
      height_q <= IMG_H_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[IMG_H_W-1:0];
      endcase
    end
  end

  // Handshake and pipeline control
  logic             in_acc;
  logic             s1_adv;
  logic             s1_valid_q, s1_valid_d;
  logic             out_valid_q, out_valid_d;
  s1_t              s1_q, s1_d;
  out_t             out_q, out_d;

  assign s1_adv    = s1_valid_q && (!out_valid_q || pix_o.ready);
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign in_acc    = pix_i.valid && pix_i.ready;

  // Effective frame size and position of the arriving pixel
  logic [WW-1:0]      w_ext, w_max, w_eff, col_p1;
  logic [IMG_H_W-1:0] h_eff;
  logic [IMG_H_W:0]   row_p1;
  logic               last_col, last_row;
  logic [AW-1:0]      col_q, col_d;
  logic [IMG_H_W-1:0] row_q, row_d;
  logic [AW-1:0]      rd_addr_a, rd_addr_b;

  always_comb begin
    w_ext = WW'(width_q);
    w_max = WW'(MAX_WIDTH);
    if (w_ext == '0) begin
      w_eff = WW'(1);
    end else if (w_ext > w_max) begin
      w_eff = w_max;
    end else begin
      w_eff = w_ext;
    end
    h_eff    = (height_q == '0) ? IMG_H_W'(1) : height_q;
    col_p1   = WW'(col_q) + WW'(1);
    row_p1   = {1'b0, row_q} + (IMG_H_W + 1)'(1);
    last_col = (col_p1 >= w_eff);
    last_row = (row_p1 >= {1'b0, h_eff});

    // advance counters
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_p1[IMG_H_W-1:0];
    end else begin
      col_d = col_q + AW'(1);
      row_d = row_q;
    end

    // upper and upper-right entries of this pixel
    rd_addr_a = col_q;
    rd_addr_b = col_q + AW'(1);

    s1_d.pix      = pix_i.pixel_in;
    s1_d.col      = col_q;
    s1_d.has_up   = (row_q != '0);
    s1_d.has_ur   = (row_q != '0) && !last_col;
    s1_d.has_left = (col_q != '0);
    s1_d.eol      = last_col;
    s1_d.eof      = last_col && last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Row error memory: read on accept, write back when the pixel completes
  logic [ERR_W-1:0] row_mem [MAX_WIDTH];
  logic [ERR_W-1:0] rd_a_q, rd_b_q;
  logic signed [ERR_W-1:0] e_err;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      row_mem[s1_q.col] <= e_err;
    end
    if (in_acc) begin
      rd_a_q <= row_mem[rd_addr_a];
      rd_b_q <= row_mem[rd_addr_b];
    end
  end

  // Forward a write that lands on the same edge as the read
  logic             byp_a_q, byp_b_q;
  logic [ERR_W-1:0] byp_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_a_q <= 1'b0;
      byp_b_q <= 1'b0;
    end else if (in_acc) begin
      byp_a_q <= s1_adv && (s1_q.col == rd_addr_a);
      byp_b_q <= s1_adv && (s1_q.col == rd_addr_b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byp_data_q <= e_err;
    end
  end

  // Compute stage: add diffused terms, threshold, form the error
  logic signed [ERR_W-1:0] ul_q, left_q;
  logic signed [ERR_W-1:0] up_err, ur_err;
  logic [PIX_W-1:0]        v1, v2, v3, v4, n_pix;

  always_comb begin
    up_err = $signed(byp_a_q ? byp_data_q : rd_a_q);
    ur_err = $signed(byp_b_q ? byp_data_q : rd_b_q);
    v1 = (s1_q.has_up && s1_q.has_left) ? add_clamp(s1_q.pix, err_term(ul_q, K_UL))
                                        : s1_q.pix;
    v2 = s1_q.has_up   ? add_clamp(v1, err_term(up_err, K_UP))   : v1;
    v3 = s1_q.has_ur   ? add_clamp(v2, err_term(ur_err, K_UR))   : v2;
    v4 = s1_q.has_left ? add_clamp(v3, err_term(left_q, K_LEFT)) : v3;
    n_pix = (v4 > PIX_THRESH) ? PIX_MAX : '0;
    e_err = $signed(ERR_W'(v4 - n_pix));

    out_d.pixel_out    = n_pix;
    out_d.end_of_line  = s1_q.eol;
    out_d.end_of_frame = s1_q.eof;
  end

  always_comb begin
    s1_valid_d  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    out_valid_d = s1_adv ? 1'b1 : (pix_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        left_q <= e_err;
      end
    end
  end

  // Payload registers: hold the stage item and the result, keep upper-left
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      out_q <= out_d;
      ul_q  <= up_err;
    end
  end

  assign pix_o.valid        = out_valid_q;
  assign pix_o.pixel_out    = out_q.pixel_out;
  assign pix_o.end_of_line  = out_q.end_of_line;
  assign pix_o.end_of_frame = out_q.end_of_frame;

  // Checks
  `EDDG_ASSERT_SAME(a_pix_binary, out_valid_q,
    out_q.pixel_out == '0 || out_q.pixel_out == PIX_MAX, "dithered pixel not 0 or 255")
  `EDDG_ASSERT_SAME(a_eof_has_eol, out_valid_q && out_q.end_of_frame,
    out_q.end_of_line, "end of frame without end of line")
  `EDDG_ASSERT_SAME(a_bypass_row_start, s1_valid_q && (byp_a_q || byp_b_q),
    s1_q.col == '0, "row memory forwarding away from row start")
  `EDDG_ASSERT_NEXT(a_stage_hold, s1_valid_q && !s1_adv,
    s1_valid_q && $stable(s1_q), "stalled compute stage lost its item")

endmodule

@@ bench/tb_error_diffusion_dither_gray.sv @@
// Self-checking testbench for the gray error-diffusion dither block.
`timescale 1ns / 1ps

module tb_error_diffusion_dither_gray;
  import eddg_pkg::*;

  localparam int          ROW_STORE_DEPTH = 4096;
  localparam int unsigned RANDOM_ITEMS    = 340;
  localparam int          SETTLE_CYCLES   = 6;
  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam int          MAX_REPORTS     = 10;

  // Diffusion weights in sixteenths and the output threshold
  localparam int WEIGHT_UL    = 1;
  localparam int WEIGHT_UP    = 5;
  localparam int WEIGHT_UR    = 3;
  localparam int WEIGHT_LEFT  = 7;
  localparam int LEVEL_THRESH = 127;
  localparam int LEVEL_WHITE  = 255;

  typedef enum int {
    IDLE_NONE,
    IDLE_SOURCE,
    IDLE_SINK,
    IDLE_BOTH
  } idle_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  eddg_in_if  pix_in ();
  eddg_out_if pix_out ();

  error_diffusion_dither_gray i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_in),
    .pix_o      (pix_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Mirror of the block state used to predict each dithered pixel
  logic signed [7:0]  row_err [ROW_STORE_DEPTH] = '{default: '0};
  logic signed [7:0]  left_err   = '0;
  int unsigned        col_pos    = 0;
  int unsigned        row_pos    = 0;
  logic [IMG_W_W-1:0] cfg_width  = 13'd640;
  logic [IMG_H_W-1:0] cfg_height = 16'd480;

  out_t        dithered_q[$];
  int unsigned mismatch_count = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned snk_stall_pct  = 0;
  int unsigned quiet_cycles   = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // floor(e * k / 16)
  function automatic int diffuse(logic signed [7:0] err, int weight);
    int prod;
    prod = int'(err) * weight;
    return prod >>> 4;
  endfunction

  function automatic int clamp_add(int level, int term);
    int sum;
    sum = level + term;
    if (sum < 0) return 0;
    if (sum > LEVEL_WHITE) return LEVEL_WHITE;
    return sum;
  endfunction

  // Correct, threshold and advance the raster position for one gray pixel
  function automatic out_t dither_pixel(logic [7:0] gray);
    int unsigned w, h, x;
    bit          last_col, last_row;
    int          level, err;
    out_t        res;
    w = cfg_width;
    h = cfg_height;
    x = col_pos;
    if (w == 0) w = 1;
    if (w > ROW_STORE_DEPTH) w = ROW_STORE_DEPTH;
    if (h == 0) h = 1;
    if (x >= ROW_STORE_DEPTH) x = ROW_STORE_DEPTH - 1;
    last_col = (x + 1 >= w);
    last_row = (row_pos + 1 >= h);
    level = gray;
    if (row_pos > 0) begin
      if (x > 0) level = clamp_add(level, diffuse(row_err[x-1], WEIGHT_UL));
      level = clamp_add(level, diffuse(row_err[x], WEIGHT_UP));
      if (!last_col) level = clamp_add(level, diffuse(row_err[x+1], WEIGHT_UR));
    end
    if (x > 0) level = clamp_add(level, diffuse(left_err, WEIGHT_LEFT));
    res.pixel_out    = (level > LEVEL_THRESH) ? 8'(LEVEL_WHITE) : 8'd0;
    res.end_of_line  = last_col;
    res.end_of_frame = last_col && last_row;
    err = level - int'(res.pixel_out);
    // upper-left entry is replaced only after it has been read
    if (x > 0) row_err[x-1] = left_err;
    if (last_col) row_err[x] = 8'(err);
    left_err = 8'(err);
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : ((row_pos + 1) & 32'hFFFF);
    end else begin
      col_pos = x + 1;
    end
    return res;
  endfunction

  // Mostly stress levels around the threshold and the rails
  function automatic logic [7:0] pick_gray();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd127;
      3: return 8'd128;
      4, 5: return 8'($urandom_range(120, 136));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic pick_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end
      IDLE_SOURCE: begin
        src_idle_pct  = 52;
        snk_stall_pct = 0;
      end
      IDLE_SINK: begin
        src_idle_pct  = 0;
        snk_stall_pct = 52;
      end
      default: begin
        src_idle_pct  = 11;
        snk_stall_pct = 11;
      end
    endcase
  endtask

  // Offer one pixel from a falling edge; return at the falling edge after it is taken
  task automatic send_gray(logic [7:0] gray);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_in.valid    <= 1'b1;
    pix_in.pixel_in <= gray;
    do @(posedge clk_i); while (!pix_in.ready);
    dithered_q.push_back(dither_pixel(gray));
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every pixel in flight has come out
  task automatic drain_pipeline();
    pix_in.valid <= 1'b0;
    while (dithered_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == REG_IMAGE_WIDTH) cfg_width = value[IMG_W_W-1:0];
    else cfg_height = value[IMG_H_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_geometry(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    drain_pipeline();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  task automatic note_mismatch(string what, int want, int got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  // Check each dithered pixel against the oldest prediction
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      if (dithered_q.size() == 0) begin
        note_mismatch("unexpected pixel_out", -1, pix_out.pixel_out);
      end else begin
        want = dithered_q.pop_front();
        if (pix_out.pixel_out !== want.pixel_out)
          note_mismatch("pixel_out", want.pixel_out, pix_out.pixel_out);
        if (pix_out.end_of_line !== want.end_of_line)
          note_mismatch("end_of_line", want.end_of_line, pix_out.end_of_line);
        if (pix_out.end_of_frame !== want.end_of_frame)
          note_mismatch("end_of_frame", want.end_of_frame, pix_out.end_of_frame);
      end
    end
  end

  // Stall the output side at random
  always @(negedge clk_i) begin
    pix_out.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // End the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reset geometry: a few pixels into the first 640-pixel row
  task automatic test_reset_geometry();
    pick_idling(IDLE_NONE);
    repeat (12) send_gray(pick_gray());
  endtask

  // Narrow width and height while a frame is under way
  task automatic test_midframe_reconfig();
    drain_pipeline();
    write_reg(REG_IMAGE_WIDTH, 16'd4);
    repeat (9) send_gray(pick_gray());
    drain_pipeline();
    write_reg(REG_IMAGE_HEIGHT, 16'd1);
    repeat (4) send_gray(pick_gray());
    // tall single-column frame, cut short mid-frame
    write_geometry(16'd1, 16'hFFFF);
    repeat (20) send_gray(pick_gray());
    drain_pipeline();
    write_reg(REG_IMAGE_HEIGHT, 16'd5);
    repeat (6) send_gray(pick_gray());
  endtask

  // Rails, threshold neighbors and runs of largest positive and negative error
  task automatic test_extreme_levels();
    logic [7:0] levels [20];
    levels = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd255,
               8'd128, 8'd127, 8'd0, 8'd255, 8'd128,
               8'd127, 8'd127, 8'd127, 8'd127, 8'd127,
               8'd128, 8'd128, 8'd128, 8'd128, 8'd128};
    write_geometry(16'd5, 16'd4);
    foreach (levels[i]) send_gray(levels[i]);
  endtask

  // Zero sizes, and a width beyond the row store cut short by narrowing
  task automatic test_degenerate_geometry();
    write_geometry(16'd0, 16'd0);
    repeat (3) send_gray(pick_gray());
    write_geometry(16'h1FFF, 16'd2);
    repeat (40) send_gray(pick_gray());
    drain_pipeline();
    write_reg(REG_IMAGE_WIDTH, 16'd40);
    repeat (41) send_gray(pick_gray());
  endtask

  // Whole frames of random small geometry, some streamed back to back
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned w, h;
    sent = 0;
    w = 1;
    h = 1;
    while (sent < RANDOM_ITEMS) begin
      if (sent == 0 || $urandom_range(3) != 0) begin
        w = ($urandom_range(7) == 0) ? $urandom_range(11, 64) : $urandom_range(1, 10);
        h = $urandom_range(1, 6);
        write_geometry(16'(w), 16'(h));
      end
      pick_idling(idle_mode_e'($urandom_range(3)));
      repeat (w * h) send_gray(pick_gray());
      sent += w * h;
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_IMAGE_WIDTH;
    cfg_data_i      = '0;
    pix_in.valid    = 1'b0;
    pix_in.pixel_in = '0;
    pix_out.ready   = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_geometry();
    test_midframe_reconfig();
    test_extreme_levels();
    test_degenerate_geometry();
    test_random_frames();

    pick_idling(IDLE_NONE);
    drain_pipeline();
    if (mismatch_count == 0 && dithered_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/eddg_pkg.sv
sv/eddg_in_if.sv
sv/eddg_out_if.sv
sv/error_diffusion_dither_gray.sv
bench/tb_error_diffusion_dither_gray.sv
